// ===== rtl/swbs_pkg.sv =====
// package for the square window box sum unit
// shared sizes, configuration register codes and the result word type
`timescale 1ns / 1ps

package swbs_pkg;

	localparam int MAX_IMAGE_DEF  = 1024;
	localparam int MAX_WINDOW_DEF = 32;

	localparam int IMG_REG_W  = 11;
	localparam int WIN_REG_W  = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	localparam int PIXEL_W    = 32;
	localparam int VALUE_W    = 62;
	localparam int OUT_DATA_W = 64;

	// result queue depth, a power of two
	localparam int OUTQ_DEPTH = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_SIZE  = 1'b0,
		REG_WINDOW_SIZE = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               is_total;
		logic               last;
	} out_word_t;

endpackage

// ===== rtl/swbs_ram.sv =====
// generic simple dual port ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module swbs_ram #(
	parameter int W = 32,
	parameter int DEPTH = 1024,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [W-1:0]      wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [W-1:0]      rdata
);

	logic [W-1:0] mem [DEPTH];

	// read returns the old contents when both ports hit the same entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/swbs_outq.sv =====
// result queue: takes up to two words per cycle, hands out one
// depends on swbs_pkg
`timescale 1ns / 1ps

module swbs_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_a,
	input  swbs_pkg::out_word_t word_a,
	input  logic               push_b,
	input  swbs_pkg::out_word_t word_b,
	output logic               out_valid,
	input  logic               out_ready,
	output swbs_pkg::out_word_t out_word
);

	import swbs_pkg::*;

	localparam int PTR_W = $clog2(OUTQ_DEPTH);
	localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

	out_word_t         entry_q [OUTQ_DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [CNT_W-1:0]  count_q;
	logic [PTR_W-1:0]  wr_b;
	logic              pop;
	logic [1:0]        n_push;

	assign pop       = out_valid && out_ready;
	assign wr_b      = wr_q + PTR_W'(push_a);
	assign n_push    = 2'(push_a) + 2'(push_b);
	assign out_valid = (count_q != '0);
	assign out_word  = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push_a) begin
			entry_q[wr_q] <= word_a;
		end
		if (push_b) begin
			entry_q[wr_b] <= word_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_W'(n_push);
			rd_q    <= rd_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(n_push) - CNT_W'(pop);
		end
	end

endmodule

// ===== rtl/square_window_box_sum_unit.sv =====
// top level of the square window box sum unit
// depends on swbs_pkg, swbs_ram and swbs_outq
`timescale 1ns / 1ps

// Pixels of a square image enter in raster order on the s_axis channel, one
// signed 32-bit sample per word. For every position where an m by m window
// fits, the m_axis channel returns the window sum in raster order of window
// position (tuser low). On the image's last pixel a word with the total of
// all window sums follows, with tuser and tlast high.
// Image side and window side are set through the cfg port while the unit is
// idle; they are picked up on the first pixel of each image.
// Throughput is one pixel per clock while s_axis_tready is high. The last
// pixel of an image can yield two words, its window sum and the total.
// A pixel's words pass the ram read, column sum, row sum and grand total,
// then the result queue, on their way to m_axis.
// The column sums and the line store live in block rams, read in the cycle
// before the update; a write to the entry that the next pixel reads is
// forwarded. s_axis_tready drops once the result queue plus the words still
// in flight could overflow the eight-entry queue; a stalled receiver thus
// stops the input before the queue overflows. Reset clears all counters, the
// running sums and the queue; sizes go back to one. No clearing pass is
// needed: the first row of every image overwrites the column sums.
module square_window_box_sum_unit #(
	parameter int MAX_IMAGE  = swbs_pkg::MAX_IMAGE_DEF,
	parameter int MAX_WINDOW = swbs_pkg::MAX_WINDOW_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [swbs_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [swbs_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [swbs_pkg::PIXEL_W-1:0]      s_axis_tdata,   // [31:0] pixel
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [swbs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // [61:0] value, rest zero
	output logic [0:0]                        m_axis_tuser,   // [0] is_total
	output logic                              m_axis_tlast
);

	import swbs_pkg::*;

	localparam int IDX_W  = (MAX_IMAGE > 1) ? $clog2(MAX_IMAGE) : 1;
	localparam int N_W    = $clog2(MAX_IMAGE + 1);
	localparam int RM_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int WB     = $clog2(MAX_WINDOW);
	localparam int COL_W  = PIXEL_W + WB + 1;
	localparam int HSUM_W = COL_W + WB + 1;
	localparam int SLOT_W = RM_W + IDX_W;
	localparam int MW_W   = $clog2(MAX_WINDOW + 1);
	localparam int A_W    = (N_W > WIN_REG_W) ? N_W : WIN_REG_W;
	localparam int E_W    = ((A_W > MW_W) ? A_W : MW_W) + 1;
	localparam int SZ_W   = ((N_W > IMG_REG_W) ? N_W : IMG_REG_W) + 1;
	localparam int PEND_W = $clog2(OUTQ_DEPTH + 1);

	// configuration
	logic [IMG_REG_W-1:0] image_size_q;
	logic [WIN_REG_W-1:0] window_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q  <= IMG_REG_W'(1);
			window_size_q <= WIN_REG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_IMAGE_SIZE:  image_size_q  <= cfg_data[IMG_REG_W-1:0];
				REG_WINDOW_SIZE: window_size_q <= cfg_data[WIN_REG_W-1:0];
			endcase
		end
	end

	// position counters and sizes of the image in progress
	logic [IDX_W-1:0]     r_q, c_q;
	logic [RM_W-1:0]      rm_q;
	logic [N_W-1:0]       cur_n_q;
	logic [WIN_REG_W-1:0] cur_m_q;
	logic [PEND_W-1:0]    pend_q;

	logic                 accept;
	logic                 start0;
	logic [SZ_W-1:0]      img_ext;
	logic [N_W-1:0]       n_new, n0;
	logic [WIN_REG_W-1:0] m0;
	logic [E_W-1:0]       r_e, c_e, m_e, n_e, rm_e, cm_e;
	logic                 win0, sub_hist0, sub_cm0, emit0, last0;
	logic                 c_wrap, r_wrap;
	logic [IDX_W-1:0]     cm_addr0;
	logic [SLOT_W-1:0]    slot0;
	logic [1:0]           words0;

	assign s_axis_tready = (pend_q <= PEND_W'(OUTQ_DEPTH - 2));
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		start0  = (r_q == '0) && (c_q == '0);
		img_ext = SZ_W'(image_size_q);
		if (img_ext == '0) begin
			n_new = N_W'(1);
		end else if (img_ext > SZ_W'(MAX_IMAGE)) begin
			n_new = N_W'(MAX_IMAGE);
		end else begin
			n_new = img_ext[N_W-1:0];
		end
		n0 = start0 ? n_new : cur_n_q;
		m0 = start0 ? window_size_q : cur_m_q;

		r_e  = E_W'(r_q);
		c_e  = E_W'(c_q);
		m_e  = E_W'(m0);
		n_e  = E_W'(n0);
		rm_e = E_W'(rm_q);
		cm_e = c_e - m_e;

		win0      = (m0 != '0) && (m_e <= E_W'(MAX_WINDOW)) && (m_e <= n_e);
		sub_hist0 = (r_e >= m_e);
		sub_cm0   = (c_e >= m_e);
		emit0     = win0 && (r_e + E_W'(1) >= m_e) && (c_e + E_W'(1) >= m_e);
		c_wrap    = (c_e + E_W'(1) == n_e);
		r_wrap    = (r_e + E_W'(1) == n_e);
		last0     = c_wrap && r_wrap;
		cm_addr0  = cm_e[IDX_W-1:0];
		slot0     = {rm_q, c_q};
		words0    = 2'(emit0) + 2'(last0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q     <= '0;
			c_q     <= '0;
			rm_q    <= '0;
			cur_n_q <= N_W'(1);
			cur_m_q <= WIN_REG_W'(1);
		end else if (accept) begin
			cur_n_q <= n0;
			cur_m_q <= m0;
			if (c_wrap) begin
				c_q <= '0;
				if (r_wrap) begin
					r_q  <= '0;
					rm_q <= '0;
				end else begin
					r_q <= r_q + IDX_W'(1);
					if (rm_e + E_W'(1) == m_e) begin
						rm_q <= '0;
					end else begin
						rm_q <= rm_q + RM_W'(1);
					end
				end
			end else begin
				c_q <= c_q + IDX_W'(1);
			end
		end
	end

	// words promised to the result queue and not yet taken
	logic out_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + (accept ? PEND_W'(words0) : '0) - PEND_W'(out_pop);
		end
	end

	// stage 1: ram data arrives, column sum update
	logic                        v_s1, win_s1, first_row_s1, sub_hist_s1, sub_cm_s1;
	logic                        c0_s1, emit_s1, last_s1, start_s1;
	logic                        fwd_a_s1, fwd_b_s1, fwd_h_s1;
	logic signed [PIXEL_W-1:0]   x_s1;
	logic [IDX_W-1:0]            c_s1;
	logic [SLOT_W-1:0]           slot_s1;

	// stage 2: row running sum
	logic                        v_s2, win_s2, c0_s2, sub_cm_s2, emit_s2, last_s2, start_s2;
	logic signed [PIXEL_W-1:0]   x_s2;
	logic signed [COL_W-1:0]     col_s2, colb_s2;

	logic                        wr_s1;
	logic signed [PIXEL_W-1:0]   hist_rd, hist_val;
	logic signed [COL_W-1:0]     cola_rd, colb_rd, cola_val, colb_val;
	logic signed [COL_W-1:0]     x_ext, hist_ext, col_base, col_sub, col_s1;

	assign wr_s1 = v_s1 && win_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1         <= s_axis_tdata;
			c_s1         <= c_q;
			slot_s1      <= slot0;
			win_s1       <= win0;
			first_row_s1 <= (r_q == '0);
			sub_hist_s1  <= sub_hist0;
			sub_cm_s1    <= sub_cm0;
			c0_s1        <= (c_q == '0);
			emit_s1      <= emit0;
			last_s1      <= last0;
			start_s1     <= start0;
			// the item in stage 1 writes this cycle, which the ram read misses
			fwd_a_s1     <= wr_s1 && (c_s1 == c_q);
			fwd_b_s1     <= wr_s1 && (c_s1 == cm_addr0);
			fwd_h_s1     <= wr_s1 && (slot_s1 == slot0);
		end
	end

	swbs_ram #(.W(PIXEL_W), .DEPTH(2 ** SLOT_W)) u_hist_ram (
		.clk  (clk),
		.we   (wr_s1),
		.waddr(slot_s1),
		.wdata(x_s1),
		.re   (accept),
		.raddr(slot0),
		.rdata(hist_rd)
	);

	swbs_ram #(.W(COL_W), .DEPTH(MAX_IMAGE)) u_cola_ram (
		.clk  (clk),
		.we   (wr_s1),
		.waddr(c_s1),
		.wdata(col_s1),
		.re   (accept),
		.raddr(c_q),
		.rdata(cola_rd)
	);

	// second copy of the column sums, read m columns back
	swbs_ram #(.W(COL_W), .DEPTH(MAX_IMAGE)) u_colb_ram (
		.clk  (clk),
		.we   (wr_s1),
		.waddr(c_s1),
		.wdata(col_s1),
		.re   (accept),
		.raddr(cm_addr0),
		.rdata(colb_rd)
	);

	always_comb begin
		hist_val = fwd_h_s1 ? x_s2 : hist_rd;
		cola_val = fwd_a_s1 ? col_s2 : cola_rd;
		colb_val = fwd_b_s1 ? col_s2 : colb_rd;
		x_ext    = COL_W'(x_s1);
		hist_ext = COL_W'(hist_val);
		col_base = first_row_s1 ? '0 : cola_val;
		col_sub  = sub_hist_s1 ? hist_ext : '0;
		col_s1   = col_base + x_ext - col_sub;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			x_s2      <= x_s1;
			col_s2    <= col_s1;
			colb_s2   <= colb_val;
			win_s2    <= win_s1;
			c0_s2     <= c0_s1;
			sub_cm_s2 <= sub_cm_s1;
			emit_s2   <= emit_s1;
			last_s2   <= last_s1;
			start_s2  <= start_s1;
		end
	end

	logic signed [HSUM_W-1:0] hsum_q, h_s2, col_h, colb_h, h_base, h_sub;

	always_comb begin
		col_h  = HSUM_W'(col_s2);
		colb_h = HSUM_W'(colb_s2);
		h_base = c0_s2 ? '0 : hsum_q;
		h_sub  = sub_cm_s2 ? colb_h : '0;
		h_s2   = h_base + col_h - h_sub;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsum_q <= '0;
		end else if (v_s2 && win_s2) begin
			hsum_q <= h_s2;
		end
	end

	// stage 3: grand total and result words
	logic                     v_s3, emit_s3, last_s3, start_s3;
	logic signed [HSUM_W-1:0] h_s3;
	logic signed [VALUE_W-1:0] gt_q, gt_base, gt_add, gt_next, h_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			h_s3     <= h_s2;
			emit_s3  <= emit_s2;
			last_s3  <= last_s2;
			start_s3 <= start_s2;
		end
	end

	always_comb begin
		h_val   = VALUE_W'(h_s3);
		gt_base = start_s3 ? '0 : gt_q;
		gt_add  = emit_s3 ? h_val : '0;
		gt_next = gt_base + gt_add;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gt_q <= '0;
		end else if (v_s3) begin
			gt_q <= gt_next;
		end
	end

	out_word_t word_a, word_b, head;
	logic      push_a, push_b;

	always_comb begin
		push_a          = v_s3 && emit_s3;
		push_b          = v_s3 && last_s3;
		word_a.value    = h_val;
		word_a.is_total = 1'b0;
		word_a.last     = 1'b0;
		word_b.value    = gt_next;
		word_b.is_total = 1'b1;
		word_b.last     = 1'b1;
	end

	swbs_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_a   (push_a),
		.word_a   (word_a),
		.push_b   (push_b),
		.word_b   (word_b),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_word (head)
	);

	assign out_pop         = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata    = {(OUT_DATA_W - VALUE_W)'(0), head.value};
	assign m_axis_tuser[0] = head.is_total;
	assign m_axis_tlast    = head.last;

endmodule

// ===== rtl/swbs_chk.sv =====
// port checker for the square window box sum unit, bound to the top level
// depends on swbs_pkg
`timescale 1ns / 1ps

module swbs_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [swbs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [0:0]                      m_axis_tuser,
	input logic                            m_axis_tlast
);

	import swbs_pkg::*;

	// a stalled word stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output word dropped while stalled");

	// only the grand total closes an image
	a_total_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[0] == m_axis_tlast))
		else $error("total flag and last flag disagree");

	// value is sign-free padding above the 62-bit field
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[OUT_DATA_W-1:VALUE_W] == '0))
		else $error("padding bits of tdata not zero");

	// queue is empty while reset is held
	a_reset: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("output valid during reset");

endmodule

bind square_window_box_sum_unit swbs_chk u_swbs_chk (.*);

// ===== dv/swbs_checker.sv =====
// result checker for the square window box sum unit
// tracks the size registers, predicts window sums and image totals, compares m_axis words
// depends on swbs_pkg
`timescale 1ns / 1ps

module swbs_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [swbs_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [swbs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [swbs_pkg::PIXEL_W-1:0]    s_axis_tdata,   // [31:0] pixel
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [swbs_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // [61:0] value, rest zero
	input  logic [0:0]                      m_axis_tuser,   // [0] is_total
	input  logic                            m_axis_tlast,
	output int                              mismatches,
	output int                              outstanding,
	output int                              words_checked
);
	import swbs_pkg::*;

	localparam int LINE_ROWS = MAX_WINDOW_DEF;
	localparam int LINE_COLS = MAX_IMAGE_DEF;

	out_word_t              sums_due[$];
	logic [PIXEL_W-1:0]     line_store [LINE_ROWS*LINE_COLS];
	logic [63:0]            col_acc [LINE_COLS];
	logic [63:0]            row_acc;
	logic [63:0]            window_total;
	int unsigned            row_pos, col_pos;
	int unsigned            img_side, win_side;
	logic [IMG_REG_W-1:0]   img_side_reg;
	logic [WIN_REG_W-1:0]   win_side_reg;

	task automatic note_mismatch(input string what);
		$display("%0t swbs_checker mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	task automatic predict_box_sums(input logic [PIXEL_W-1:0] pix);
		logic [63:0] x, colv, h;
		int unsigned n, m, r, c, slot;
		logic        fits;
		out_word_t   w;
		x = {{32{pix[31]}}, pix};
		// sizes are picked up on the first pixel of each image
		if (row_pos == 0 && col_pos == 0) begin
			img_side = (img_side_reg == 0) ? 1 : img_side_reg;
			if (img_side > LINE_COLS)
				img_side = LINE_COLS;
			win_side = win_side_reg;
			window_total = '0;
		end
		n = img_side;
		m = win_side;
		r = row_pos;
		c = col_pos;
		fits = (m >= 1) && (m <= LINE_ROWS) && (m <= n);
		if (fits) begin
			slot = (r % m) * LINE_COLS + c;
			colv = (r == 0) ? x : col_acc[c] + x;
			// drop the pixel that leaves the window column
			if (r >= m)
				colv -= {{32{line_store[slot][31]}}, line_store[slot]};
			line_store[slot] = pix;
			col_acc[c] = colv;
			h = (c == 0) ? colv : row_acc + colv;
			if (c >= m)
				h -= col_acc[c-m];
			row_acc = h;
			if (r + 1 >= m && c + 1 >= m) begin
				w.value    = h[VALUE_W-1:0];
				w.is_total = 1'b0;
				w.last     = 1'b0;
				sums_due.push_back(w);
				window_total += h;
			end
		end
		if (r + 1 == n && c + 1 == n) begin
			w.value    = window_total[VALUE_W-1:0];
			w.is_total = 1'b1;
			w.last     = 1'b1;
			sums_due.push_back(w);
		end
		c++;
		if (c >= n) begin
			c = 0;
			r++;
			if (r >= n)
				r = 0;
		end
		row_pos = r;
		col_pos = c;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_due.delete();
			row_acc = '0;
			window_total = '0;
			row_pos = 0;
			col_pos = 0;
			img_side = 1;
			win_side = 1;
			img_side_reg = 1;
			win_side_reg = 1;
			mismatches = 0;
			words_checked = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_IMAGE_SIZE)
					img_side_reg = cfg_data[IMG_REG_W-1:0];
				else if (cfg_idx == REG_WINDOW_SIZE)
					win_side_reg = cfg_data[WIN_REG_W-1:0];
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_box_sums(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				out_word_t due;
				words_checked++;
				if (sums_due.size() == 0) begin
					note_mismatch($sformatf("word %0d arrived with nothing due", words_checked));
				end else begin
					due = sums_due.pop_front();
					if (m_axis_tdata[VALUE_W-1:0] !== due.value)
						note_mismatch($sformatf("word %0d value %0d, want %0d", words_checked,
							$signed(m_axis_tdata[VALUE_W-1:0]), $signed(due.value)));
					if (m_axis_tdata[OUT_DATA_W-1:VALUE_W] !== '0)
						note_mismatch($sformatf("word %0d pad bits %b", words_checked,
							m_axis_tdata[OUT_DATA_W-1:VALUE_W]));
					if (m_axis_tuser[0] !== due.is_total)
						note_mismatch($sformatf("word %0d is_total %b, want %b", words_checked,
							m_axis_tuser[0], due.is_total));
					if (m_axis_tlast !== due.last)
						note_mismatch($sformatf("word %0d last %b, want %b", words_checked,
							m_axis_tlast, due.last));
				end
			end
			outstanding <= sums_due.size();
		end
	end

endmodule

// ===== dv/square_window_box_sum_unit_tb.sv =====
// testbench top for the square window box sum unit: clock, reset, pixel stimulus, verdict
// depends on swbs_pkg, square_window_box_sum_unit and swbs_checker
`timescale 1ns / 1ps

module square_window_box_sum_unit_tb;
	import swbs_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT   = 4000;
	localparam int RANDOM_QUOTA  = 70;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b1;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = REG_IMAGE_SIZE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [PIXEL_W-1:0]    s_axis_tdata = '0;   // [31:0] pixel
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;        // [61:0] value, rest zero
	logic [0:0]            m_axis_tuser;        // [0] is_total
	logic                  m_axis_tlast;

	int mismatches, outstanding, words_checked;
	int send_idle_pct = 18;
	int recv_idle_pct = 65;
	int pixels_sent = 0;
	int images_started = 0;
	int stall_cycles = 0;
	logic [CFG_DATA_W-1:0] plan_img, plan_win;
	logic sizes_preset = 1'b0;

	square_window_box_sum_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	swbs_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.words_checked (words_checked)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// stall watchdog: any accepted word on either side restarts the count
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == STALL_LIMIT) begin
			$display("stalled for %0d cycles with %0d words due", STALL_LIMIT, outstanding);
			$display("square_window_box_sum_unit_tb: errors");
			$finish;
		end
	end

	function automatic int side_of(input logic [CFG_DATA_W-1:0] v);
		if (v == 0)
			return 1;
		return (v > MAX_IMAGE_DEF) ? MAX_IMAGE_DEF : int'(v);
	endfunction

	function automatic logic [PIXEL_W-1:0] random_pixel();
		case ($urandom_range(9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2, 3, 4: return PIXEL_W'($urandom_range(200)) - 32'd100;
			default: return $urandom;
		endcase
	endfunction

	task automatic push_pixel(input logic [PIXEL_W-1:0] pix);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pix;
		do @(posedge clk); while (!s_axis_tready);
		pixels_sent++;
	endtask

	// hold the sender until every due word is out and the pipeline has emptied
	task automatic wait_quiet();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_sizes(input logic [CFG_DATA_W-1:0] img_val,
			input logic [CFG_DATA_W-1:0] win_val);
		cfg_we   <= 1'b1;
		cfg_idx  <= REG_IMAGE_SIZE;
		cfg_data <= img_val;
		@(posedge clk);
		cfg_idx  <= REG_WINDOW_SIZE;
		cfg_data <= win_val;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	// mostly small images with a fitting window, the rest oversized, zero or masked windows
	task automatic pick_sizes();
		int side, pick, win;
		pick = $urandom_range(99);
		if (pick < 3)
			plan_img = '0;
		else if (pick < 70)
			plan_img = CFG_DATA_W'($urandom_range(1, 8));
		else if (pick < 95)
			plan_img = CFG_DATA_W'($urandom_range(9, 16));
		else
			plan_img = CFG_DATA_W'($urandom_range(17, 24));
		side = side_of(plan_img);
		pick = $urandom_range(99);
		if (pick < 75) begin
			win = $urandom_range(1, (side > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : side);
			// upper data bits beyond the window register must be dropped
			if ($urandom_range(3) == 0)
				win += $urandom_range(1, 31) << WIN_REG_W;
		end else if (pick < 85) begin
			win = side + $urandom_range(1, 4);
		end else if (pick < 92) begin
			win = 0;
		end else begin
			win = ($urandom_range(31) << WIN_REG_W) | $urandom_range(33, 63);
		end
		plan_win = CFG_DATA_W'(win);
	endtask

	task automatic feed_random_images(input int quota);
		int fed, side, pixels, split_at, i;
		fed = 0;
		while (fed < quota) begin
			if (!sizes_preset) begin
				pick_sizes();
				wait_quiet();
				program_sizes(plan_img, plan_win);
			end
			sizes_preset = 1'b0;
			side = side_of(plan_img);
			pixels = side * side;
			split_at = (pixels >= 4 && $urandom_range(5) == 0) ? $urandom_range(1, pixels - 1) : -1;
			images_started++;
			for (i = 0; i < pixels; i++) begin
				// new sizes written mid-image only apply to the next image
				if (i == split_at) begin
					pick_sizes();
					wait_quiet();
					program_sizes(plan_img, plan_win);
					sizes_preset = 1'b1;
				end
				push_pixel(random_pixel());
			end
			fed += pixels;
		end
	endtask

	initial begin
		int i, phase;
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset sizes of one: every pixel is its own window and its own total
		push_pixel(32'h7fff_ffff);
		push_pixel(32'h8000_0000);
		wait_quiet();
		// image side zero acts as one
		program_sizes(11'd0, 11'd1);
		push_pixel(32'hffff_ffff);
		wait_quiet();
		// zero window and a window above the maximum: only a zero total
		program_sizes(11'd2, 11'd0);
		for (i = 0; i < 4; i++)
			push_pixel(random_pixel());
		wait_quiet();
		program_sizes(11'd2, 11'h7e1);
		for (i = 0; i < 4; i++)
			push_pixel(32'h7fff_ffff);
		wait_quiet();
		// window wider than the image, then a 2 by 2 window in a 3 by 3 image
		program_sizes(11'd1, 11'd2);
		push_pixel(32'h8000_0000);
		wait_quiet();
		program_sizes(11'd3, 11'd2);
		for (i = 0; i < 9; i++)
			push_pixel((i < 5) ? 32'h7fff_ffff : 32'h8000_0000);
		images_started += 7;

		for (phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 65 : 0;
			recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 18 : 0;
			feed_random_images(RANDOM_QUOTA);
		end

		// side register beyond the maximum saturates; run into the second row
		wait_quiet();
		program_sizes(11'h7ff, 11'd2);
		for (i = 0; i < MAX_IMAGE_DEF + 4; i++)
			push_pixel(random_pixel());
		images_started += 1;

		wait_quiet();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d images, %0d pixels, %0d result words, under three pacing modes",
			images_started, pixels_sent, words_checked);
		$display("sides 0 to a saturated 2047, windows 0 to 63 with masked writes and mid-image updates");
		if (mismatches == 0 && outstanding == 0)
			$display("square_window_box_sum_unit_tb: clean");
		else
			$display("square_window_box_sum_unit_tb: errors");
		$finish;
	end

endmodule
